// ----- hdl/thme_pkg.sv -----
package thme_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned LocW     = 17;

  typedef enum logic [1:0] {
    ROW_POINT = 2'd0,
    ROW_DU    = 2'd1,
    ROW_DV    = 2'd2,
    ROW_DW    = 2'd3
  } row_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_e;

  // Clamp a local coordinate to one.
  function automatic logic [LocW-1:0] clamp_one(input logic [LocW-1:0] c,
                                               input logic [LocW-1:0] one);
    clamp_one = (c > one) ? one : c;
  endfunction

endpackage

// ----- hdl/thme_if.sv -----
interface thme_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [2:0]        node_index;
  logic [31:0]       node_x;
  logic [31:0]       node_y;
  logic [31:0]       node_z;
  logic [16:0]       local_u;
  logic [16:0]       local_v;
  logic [16:0]       local_w;

  modport source (output valid, kind, node_index, node_x, node_y, node_z,
                  local_u, local_v, local_w, input ready);
  modport sink (input valid, kind, node_index, node_x, node_y, node_z,
                local_u, local_v, local_w, output ready);
endinterface

interface thme_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    row;
  logic [thme_pkg::CoordW:0]     vec_x;
  logic [thme_pkg::CoordW:0]     vec_y;
  logic [thme_pkg::CoordW:0]     vec_z;
  logic [63:0]                   jacobian;
  logic                          last;

  modport source (output valid, row, vec_x, vec_y, vec_z, jacobian, last,
                  input ready);
  modport sink (input valid, row, vec_x, vec_y, vec_z, jacobian, last,
                output ready);
endinterface

// ----- hdl/trilinear_hex_map_evaluator.sv -----
// Channel | Dir | Handshake   | Payload
// in_if   | in  | valid/ready | kind, node_index, node_x/y/z, local_u/v/w
// out_if  | out | valid/ready | row, vec_x/y/z, jacobian, last
//
// A load request gives no row. An evaluate request passes seven register stages
// and the output register; its four rows leave one per cycle while out_if.ready
// is high, and the output buffer takes a new evaluation only as the last row of
// the previous one is accepted. Back-to-back loads enter every cycle while no
// evaluation waits at the tail.
// Reset clears the valid bits and the row counter only; the node store is undefined until written.
// A waiting evaluation at the tail holds every stage and the input; nothing is lost.
module trilinear_hex_map_evaluator (
  input logic clk_i,
  input logic rst_ni,
  thme_in_if.sink    in_if,
  thme_out_if.source out_if
);

  localparam int unsigned CW = thme_pkg::CoordW;
  localparam int unsigned F  = thme_pkg::FracBits;
  localparam int unsigned LW = thme_pkg::LocW;
  localparam int unsigned WW = F + 2;          // weight width (holds 1.0)
  localparam int unsigned VW = CW + 1;
  localparam int unsigned AW = CW + 5;         // accumulator width
  localparam int unsigned PW = 2 * VW + 2;     // cross product width
  localparam int unsigned DW = 64 + VW + 3;    // dot product width
  localparam logic [LW-1:0] One = LW'(1) << F;
  localparam logic signed [AW-1:0] VLim = AW'((65'sd1 <<< CW) - 65'sd1);

  // node store: 8 nodes x 3 axes
  logic signed [CW-1:0] nx_q [8];
  logic signed [CW-1:0] ny_q [8];
  logic signed [CW-1:0] nz_q [8];

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  assign in_if.ready = adv;

  // Write a node on a load request.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && adv && in_if.kind == thme_pkg::KIND_LOAD) begin
      nx_q[in_if.node_index] <= CW'(in_if.node_x);
      ny_q[in_if.node_index] <= CW'(in_if.node_y);
      nz_q[in_if.node_index] <= CW'(in_if.node_z);
    end
  end

  // Stage 1: local factors and pairwise weights.
  logic [WW-1:0] l_d [6];
  logic [WW-1:0] l1_q [6];
  logic [WW-1:0] pw_q [12];   // pair weights for du, dv, dw
  always_comb begin
    l_d[0] = WW'(thme_pkg::clamp_one(LW'(in_if.local_u), One));
    l_d[1] = WW'(thme_pkg::clamp_one(LW'(in_if.local_v), One));
    l_d[2] = WW'(thme_pkg::clamp_one(LW'(in_if.local_w), One));
    for (int i = 0; i < 3; i++) l_d[3+i] = WW'(One) - l_d[i];
  end

  function automatic logic [WW-1:0] wm(input logic [WW-1:0] a,
                                       input logic [WW-1:0] b);
    logic [2*WW-1:0] p;
    p  = a * b;
    wm = WW'(p >> F);
  endfunction

  // pair weights: vw (for du), uw (for dv), uv (for dw) with indexes of model
  localparam int unsigned Tab [3][4][2] = '{
    '{'{4, 5}, '{1, 5}, '{1, 2}, '{4, 2}},
    '{'{3, 5}, '{0, 5}, '{0, 2}, '{3, 2}},
    '{'{3, 4}, '{0, 4}, '{0, 1}, '{3, 1}}};
  localparam int unsigned Nd [3][4][2] = '{
    '{'{1, 0}, '{2, 3}, '{6, 7}, '{5, 4}},
    '{'{3, 0}, '{2, 1}, '{6, 5}, '{7, 4}},
    '{'{4, 0}, '{5, 1}, '{6, 2}, '{7, 3}}};
  // The first two factors of corner k equal the uv pair weight k mod 4.
  localparam int unsigned Pt [8][3] = '{
    '{3, 4, 5}, '{0, 4, 5}, '{0, 1, 5}, '{3, 1, 5},
    '{3, 4, 2}, '{0, 4, 2}, '{0, 1, 2}, '{3, 1, 2}};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) l1_q[i] <= l_d[i];
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 4; k++)
          pw_q[i*4+k] <= wm(l_d[Tab[i][k][0]], l_d[Tab[i][k][1]]);
    end
  end

  // Stage 2: point weights (third factor), node differences.
  logic [WW-1:0] ptw_q [8];
  logic [WW-1:0] tw_q [12];
  logic signed [CW:0] df_q [12][3];
  logic signed [CW-1:0] nd_q [8][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++)
        ptw_q[k] <= wm(pw_q[8 + (k % 4)], l1_q[Pt[k][2]]);
      for (int j = 0; j < 12; j++) tw_q[j] <= pw_q[j];
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 4; k++) begin
          df_q[i*4+k][0] <= (CW+1)'(nx_q[Nd[i][k][0]]) - (CW+1)'(nx_q[Nd[i][k][1]]);
          df_q[i*4+k][1] <= (CW+1)'(ny_q[Nd[i][k][0]]) - (CW+1)'(ny_q[Nd[i][k][1]]);
          df_q[i*4+k][2] <= (CW+1)'(nz_q[Nd[i][k][0]]) - (CW+1)'(nz_q[Nd[i][k][1]]);
        end
      for (int k = 0; k < 8; k++) begin
        nd_q[k][0] <= nx_q[k];
        nd_q[k][1] <= ny_q[k];
        nd_q[k][2] <= nz_q[k];
      end
    end
  end

  // Stage 3: scaled products.
  logic signed [AW-1:0] sp_q [8][3];
  logic signed [AW-1:0] st_q [12][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++)
        for (int a = 0; a < 3; a++)
          sp_q[k][a] <= AW'((48'(nd_q[k][a]) * $signed({1'b0, ptw_q[k]})) >>> F);
      for (int j = 0; j < 12; j++)
        for (int a = 0; a < 3; a++)
          st_q[j][a] <= AW'((49'(df_q[j][a]) * $signed({1'b0, tw_q[j]})) >>> F);
    end
  end

  function automatic logic signed [VW-1:0] clampv(input logic signed [AW-1:0] x);
    if (x > VLim) clampv = VW'(VLim);
    else if (x < -VLim) clampv = VW'(-VLim);
    else clampv = VW'(x);
  endfunction

  // Stage 4: sums and clamp into four vectors.
  logic signed [VW-1:0] vec_q [4][3];
  always_ff @(posedge clk_i) begin
    logic signed [AW-1:0] s;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        s = '0;
        for (int k = 0; k < 8; k++) s = s + sp_q[k][a];
        vec_q[0][a] <= clampv(s);
        for (int i = 0; i < 3; i++) begin
          s = '0;
          for (int k = 0; k < 4; k++) s = s + st_q[i*4+k][a];
          vec_q[1+i][a] <= clampv(s);
        end
      end
    end
  end

  // Stage 5: cross product terms; stage 6: floor, saturate; stage 7: dot halves.
  logic signed [PW-1:0] cp_q [3][2];
  logic signed [VW-1:0] v5_q [4][3];
  logic v5v_q, v6v_q, v7v_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cp_q[a][0] <= PW'(vec_q[1][(a+1)%3]) * PW'(vec_q[2][(a+2)%3]);
        cp_q[a][1] <= PW'(vec_q[1][(a+2)%3]) * PW'(vec_q[2][(a+1)%3]);
      end
      v5_q <= vec_q;
    end
  end

  function automatic logic signed [63:0] sat64(input logic signed [DW-1:0] x);
    if (x > DW'(64'sh7fffffffffffffff)) sat64 = 64'sh7fffffffffffffff;
    else if (x < -DW'(64'sh7fffffffffffffff) - DW'(1)) sat64 = 64'sh8000000000000000;
    else sat64 = 64'(x);
  endfunction

  logic signed [63:0] cr_q [3];
  logic signed [VW-1:0] v6_q [4][3];
  always_ff @(posedge clk_i) begin
    logic signed [PW:0] df;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        df = (PW+1)'(cp_q[a][0]) - (PW+1)'(cp_q[a][1]);
        cr_q[a] <= sat64(DW'(df >>> F));
      end
      v6_q <= v5_q;
    end
  end

  // Split each cross term into a signed upper and an unsigned lower half.
  logic signed [65:0] ph_q [3];
  logic signed [65:0] pl_q [3];
  logic signed [VW-1:0] v7_q [4][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        ph_q[a] <= 66'($signed(cr_q[a][63:32])) * 66'(v6_q[3][a]);
        pl_q[a] <= 66'($signed({1'b0, cr_q[a][31:0]})) * 66'(v6_q[3][a]);
      end
      v7_q <= v6_q;
    end
  end

  // Recombine the halves into the full dot product.
  logic signed [DW-1:0] jac_sum;
  always_comb begin
    jac_sum = (DW'(ph_q[0]) + DW'(ph_q[1]) + DW'(ph_q[2])) <<< 32;
    jac_sum = jac_sum + DW'(pl_q[0]) + DW'(pl_q[1]) + DW'(pl_q[2]);
  end

  // Output buffer: four rows per evaluation.
  logic               ob_v_q;
  logic [1:0]         ob_row_q;
  logic signed [VW-1:0] ob_vec_q [4][3];
  logic signed [63:0] ob_jac_q;
  logic               ob_free;
  assign ob_free = !ob_v_q || (out_if.ready && ob_row_q == thme_pkg::ROW_DW);
  // The pipeline advances unless an evaluation at its tail waits.
  assign adv = !v7v_q || ob_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5v_q <= 1'b0; v6v_q <= 1'b0; v7v_q <= 1'b0;
      ob_v_q <= 1'b0; ob_row_q <= thme_pkg::ROW_POINT;
    end else begin
      if (adv) begin
        v1_q <= in_if.valid && in_if.kind == thme_pkg::KIND_EVAL;
        v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
        v5v_q <= v4_q; v6v_q <= v5v_q; v7v_q <= v6v_q;
      end
      if (v7v_q && ob_free) begin
        ob_v_q <= 1'b1;
        ob_row_q <= thme_pkg::ROW_POINT;
      end else if (ob_v_q && out_if.ready) begin
        ob_row_q <= ob_row_q + 2'd1;
        if (ob_row_q == thme_pkg::ROW_DW) ob_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v7v_q && ob_free) begin
      ob_vec_q <= v7_q;
      ob_jac_q <= sat64(jac_sum);
    end
  end

  assign out_if.valid    = ob_v_q;
  assign out_if.row      = ob_row_q;
  assign out_if.vec_x    = ob_vec_q[ob_row_q][0];
  assign out_if.vec_y    = ob_vec_q[ob_row_q][1];
  assign out_if.vec_z    = ob_vec_q[ob_row_q][2];
  assign out_if.last     = (ob_row_q == thme_pkg::ROW_DW);
  assign out_if.jacobian = out_if.last ? ob_jac_q : 64'sd0;

endmodule

// ----- test/thme_checker.sv -----
module thme_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  thme_in_if          in_mon,
  thme_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned rows_pending_o,
  output int unsigned rows_checked_o
);

  localparam longint OneFx  = 64'sd65536;
  localparam longint VecLim = 64'sd4294967295;
  localparam logic signed [127:0] S64Max = 128'sh7fffffffffffffff;
  localparam logic signed [127:0] S64Min = -S64Max - 128'sd1;

  // Factor pair and node pair per tangent term: a, b, plus node, minus node.
  localparam int unsigned TanTerm [3][4][4] = '{
    '{'{4, 5, 1, 0}, '{1, 5, 2, 3}, '{1, 2, 6, 7}, '{4, 2, 5, 4}},
    '{'{3, 5, 3, 0}, '{0, 5, 2, 1}, '{0, 2, 6, 5}, '{3, 2, 7, 4}},
    '{'{3, 4, 4, 0}, '{0, 4, 5, 1}, '{0, 1, 6, 2}, '{3, 1, 7, 3}}
  };
  // Three local factors forming each corner's point weight.
  localparam int unsigned PointTerm [8][3] = '{
    '{3, 4, 5}, '{0, 4, 5}, '{0, 1, 5}, '{3, 1, 5},
    '{3, 4, 2}, '{0, 4, 2}, '{0, 1, 2}, '{3, 1, 2}
  };

  typedef struct {
    thme_pkg::row_e row;
    logic [32:0]    vec_x;
    logic [32:0]    vec_y;
    logic [32:0]    vec_z;
    logic [63:0]    jacobian;
    logic           last;
  } hex_row_t;

  hex_row_t    rows_due[$];
  longint      node_coord[8][3];
  int unsigned mismatches;
  int unsigned rows_seen;
  int unsigned rows_queued;

  assign fail_count_o   = mismatches;
  assign rows_pending_o = rows_queued;
  assign rows_checked_o = rows_seen;

  function automatic logic signed [127:0] widen(input longint x);
    logic signed [127:0] r;
    r = x;
    return r;
  endfunction

  function automatic longint sat64(input logic signed [127:0] x);
    if (x > S64Max) return S64Max[63:0];
    if (x < S64Min) return S64Min[63:0];
    return x[63:0];
  endfunction

  function automatic longint clamp_vec(input longint x);
    if (x > VecLim) return VecLim;
    if (x < -VecLim) return -VecLim;
    return x;
  endfunction

  // Floor of a coordinate times a weight, dropping the fraction bits.
  function automatic longint weigh(input longint d, input longint wt);
    return (d * wt) >>> 16;
  endfunction

  // Evaluate the map, its tangents and the Jacobian; queue the four rows.
  task automatic predict_rows(input logic [16:0] lu, input logic [16:0] lv,
                              input logic [16:0] lw);
    longint              fac[6];
    longint              vec[4][3];
    longint              cr[3];
    longint              c;
    longint              wt;
    longint              s;
    logic [16:0]         loc[3];
    logic signed [127:0] acc;
    int unsigned         p;
    int unsigned         q;
    hex_row_t            r;
    loc[0] = lu;
    loc[1] = lv;
    loc[2] = lw;
    for (int i = 0; i < 3; i++) begin
      c = longint'(loc[i]);
      if (c > OneFx) c = OneFx;
      fac[i]     = c;
      fac[3 + i] = OneFx - c;
    end
    for (int a = 0; a < 3; a++) begin
      s = 0;
      for (int k = 0; k < 8; k++) begin
        wt = (fac[PointTerm[k][0]] * fac[PointTerm[k][1]]) >> 16;
        wt = (wt * fac[PointTerm[k][2]]) >> 16;
        s += weigh(node_coord[k][a], wt);
      end
      vec[0][a] = clamp_vec(s);
    end
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        s = 0;
        for (int k = 0; k < 4; k++) begin
          wt = (fac[TanTerm[i][k][0]] * fac[TanTerm[i][k][1]]) >> 16;
          s += weigh(node_coord[TanTerm[i][k][2]][a] - node_coord[TanTerm[i][k][3]][a],
                     wt);
        end
        vec[1 + i][a] = clamp_vec(s);
      end
    end
    for (int a = 0; a < 3; a++) begin
      p = (a + 1) % 3;
      q = (a + 2) % 3;
      acc = widen(vec[1][p]) * widen(vec[2][q]) - widen(vec[1][q]) * widen(vec[2][p]);
      cr[a] = sat64(acc >>> 16);
    end
    acc = widen(cr[0]) * widen(vec[3][0]) + widen(cr[1]) * widen(vec[3][1])
        + widen(cr[2]) * widen(vec[3][2]);
    for (int i = 0; i < 4; i++) begin
      r.row      = thme_pkg::row_e'(i);
      r.vec_x    = vec[i][0][32:0];
      r.vec_y    = vec[i][1][32:0];
      r.vec_z    = vec[i][2][32:0];
      r.jacobian = (i == 3) ? sat64(acc) : 64'd0;
      r.last     = (i == 3);
      rows_due.push_back(r);
    end
  endtask

  // Take requests, then compare each result row with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    hex_row_t want;
    if (!rst_ni) begin
      rows_due.delete();
      mismatches  = 0;
      rows_seen   = 0;
      rows_queued = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (thme_pkg::kind_e'(in_mon.kind) == thme_pkg::KIND_LOAD) begin
          node_coord[in_mon.node_index][0] = longint'(signed'(in_mon.node_x));
          node_coord[in_mon.node_index][1] = longint'(signed'(in_mon.node_y));
          node_coord[in_mon.node_index][2] = longint'(signed'(in_mon.node_z));
        end else begin
          predict_rows(in_mon.local_u, in_mon.local_v, in_mon.local_w);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        rows_seen++;
        if (rows_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected row %0d vec=(%h,%h,%h) jac=%h last=%b",
                     out_mon.row, out_mon.vec_x, out_mon.vec_y, out_mon.vec_z,
                     out_mon.jacobian, out_mon.last);
        end else begin
          want = rows_due.pop_front();
          if (out_mon.row !== want.row || out_mon.vec_x !== want.vec_x ||
              out_mon.vec_y !== want.vec_y || out_mon.vec_z !== want.vec_z ||
              out_mon.jacobian !== want.jacobian || out_mon.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: row mismatch exp row %0d vec=(%h,%h,%h) jac=%h last=%b",
                       want.row, want.vec_x, want.vec_y, want.vec_z, want.jacobian,
                       want.last);
              $display("       got row %0d vec=(%h,%h,%h) jac=%h last=%b",
                       out_mon.row, out_mon.vec_x, out_mon.vec_y, out_mon.vec_z,
                       out_mon.jacobian, out_mon.last);
            end
          end
        end
      end
      rows_queued = rows_due.size();
    end
  end

endmodule

// ----- test/tb_trilinear_hex_map_evaluator.sv -----
module tb_trilinear_hex_map_evaluator;

  localparam int unsigned ItemTarget = 420;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [16:0] LocOne     = 17'd65536;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned rows_pending;
  int unsigned rows_checked;
  int unsigned cycle_count;
  int unsigned n_items;
  int unsigned n_loads;
  int unsigned n_evals;
  bit          send_burst;
  bit          recv_burst;
  bit          drained_once;

  thme_in_if  in_if ();
  thme_out_if out_if ();

  trilinear_hex_map_evaluator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  thme_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .fail_count_o   (fail_count),
    .rows_pending_o (rows_pending),
    .rows_checked_o (rows_checked)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side for a random number of cycles per row.
  initial begin
    int unsigned hold;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = recv_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
    end
  end

  // Present one request after a random gap and hold it until taken.
  task automatic push_request(input thme_pkg::kind_e kind, input logic [2:0] idx,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [16:0] u,
                              input logic [16:0] v, input logic [16:0] w);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.node_index <= idx;
    in_if.node_x     <= x;
    in_if.node_y     <= y;
    in_if.node_z     <= z;
    in_if.local_u    <= u;
    in_if.local_v    <= v;
    in_if.local_w    <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
    if (kind == thme_pkg::KIND_LOAD) n_loads++;
    else n_evals++;
    if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
  endtask

  task automatic load_node(input logic [2:0] idx, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    push_request(thme_pkg::KIND_LOAD, idx, x, y, z, 17'($urandom), 17'($urandom),
                 17'($urandom));
  endtask

  task automatic evaluate(input logic [16:0] u, input logic [16:0] v,
                          input logic [16:0] w);
    push_request(thme_pkg::KIND_EVAL, 3'($urandom), $urandom, $urandom, $urandom,
                 u, v, w);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [16:0] rand_local();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return LocOne;
      2:       return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    bit [7:0] order_used;
    int unsigned idx;
    in_if.valid      = 1'b0;
    in_if.kind       = thme_pkg::KIND_LOAD;
    in_if.node_index = '0;
    in_if.node_x     = '0;
    in_if.node_y     = '0;
    in_if.node_z     = '0;
    in_if.local_u    = '0;
    in_if.local_v    = '0;
    in_if.local_w    = '0;
    n_items = 0;
    n_loads = 0;
    n_evals = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    drained_once = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unit cube, then corners, centre and coordinates above one.
    for (int k = 0; k < 8; k++)
      load_node(k[2:0], (k == 1 || k == 2 || k == 5 || k == 6) ? 32'h10000 : 32'h0,
                (k == 2 || k == 3 || k == 6 || k == 7) ? 32'h10000 : 32'h0,
                (k >= 4) ? 32'h10000 : 32'h0);
    evaluate(17'd0, 17'd0, 17'd0);
    evaluate(LocOne, LocOne, LocOne);
    evaluate(17'h1ffff, 17'h1ffff, 17'h1ffff);
    evaluate(17'd32768, 17'd32768, 17'd32768);
    evaluate(17'd65537, 17'd0, 17'd65535);

    // Extreme coordinates, to saturate vectors and the Jacobian.
    for (int k = 0; k < 8; k++)
      load_node(k[2:0], k[0] ? 32'h7fffffff : 32'h80000000,
                k[0] ? 32'h80000000 : 32'h7fffffff,
                (k >= 4) ? 32'h7fffffff : 32'h80000000);
    evaluate(17'd0, 17'd0, 17'd0);
    evaluate(LocOne, 17'd0, LocOne);
    evaluate(17'd32768, 17'd16384, 17'd49152);

    // Random part: mostly full node sets followed by evaluations.
    while (n_items < ItemTarget) begin
      if (!drained_once && n_items >= 200) begin
        drained_once = 1'b1;
        in_if.valid <= 1'b0;
        @(negedge clk_i);
        while (rows_pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) == 0) begin
        order_used = '0;
        for (int k = 0; k < 8; k++) begin
          do idx = $urandom_range(0, 7); while (order_used[idx]);
          order_used[idx] = 1'b1;
          load_node(idx[2:0], rand_coord(), rand_coord(), rand_coord());
        end
        repeat ($urandom_range(2, 5)) evaluate(rand_local(), rand_local(), rand_local());
      end else if ($urandom_range(0, 1) == 0) begin
        load_node(3'($urandom), rand_coord(), rand_coord(), rand_coord());
      end else begin
        evaluate(rand_local(), rand_local(), rand_local());
      end
    end
    in_if.valid <= 1'b0;

    // Drain and let the pipeline settle.
    while (rows_pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Sent %0d node loads and %0d evaluations; checked %0d result rows.",
             n_loads, n_evals, rows_checked);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/thme_pkg.sv
hdl/thme_if.sv
hdl/trilinear_hex_map_evaluator.sv
test/thme_checker.sv
test/tb_trilinear_hex_map_evaluator.sv
